### hdl/cbts_pkg.sv
// Shared types and constants of the CAN bit timing search block.
// No dependencies; taken in by the controller, the datapath, the top level and the checker.
package cbts_pkg;

    localparam int CLK_W   = 28;   // peripheral clock in hertz
    localparam int RATE_W  = 20;   // requested bit rate
    localparam int DIV_W   = 4;    // prescaler divider minus one
    localparam int WORD_W  = 15;   // packed timing word
    localparam int CNT_W   = 5;    // divide step counter
    localparam int QM1_W   = 5;    // quanta minus one
    localparam int SEGS_W  = 5;    // segment total
    localparam int STEP_W  = 10;   // quanta * (div + 1)
    localparam int PROD_W  = 15;   // segs * quanta * (div + 1)

    localparam logic [CLK_W-1:0]  CLK_RESET      = CLK_W'(48000000);
    localparam logic [CNT_W-1:0]  DIV_STEPS_LAST = CNT_W'(CLK_W - 1);
    localparam logic [SEGS_W-1:0] SEGS_FIRST     = SEGS_W'(3);
    localparam logic [SEGS_W-1:0] SEGS_LAST      = SEGS_W'(17);
    localparam logic [QM1_W-1:0]  QM1_LAST       = QM1_W'(31);
    localparam logic [DIV_W-1:0]  DIV_LAST       = DIV_W'(15);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // latch bit rate, start the divider
        logic div_step;     // one restoring divide step
        logic search_init;  // reset the combination walk
        logic search_step;  // advance to the next combination
        logic capture;      // store the current combination as the result
        logic clear;        // store a not-found result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rate_zero;    // incoming bit rate is zero
        logic div_last;     // this divide step is the final one
        logic match;        // current combination equals clocks per bit
        logic search_last;  // current combination is the final one
    } t_status;

endpackage

### hdl/cbts_datapath.sv
// Datapath of the CAN bit timing search: clock register, serial divider,
// combination walk and result registers. Depends on cbts_pkg.
module cbts_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbts_pkg::CLK_W-1:0]    i_cfg_data,
    input  logic [cbts_pkg::RATE_W-1:0]   i_bit_rate,
    input  cbts_pkg::t_cmd                i_cmd,
    output cbts_pkg::t_status             o_status,
    output logic                          o_found,
    output logic [cbts_pkg::DIV_W-1:0]    o_prescale_div,
    output logic [cbts_pkg::WORD_W-1:0]   o_timing_word
);
    import cbts_pkg::*;

    function automatic logic [WORD_W-1:0] pack_word(input logic [QM1_W-1:0]  qm1,
                                                    input logic [SEGS_W-1:0] segs);
        logic [3:0] rest;
        logic [3:0] seg1;
        logic [3:0] seg2;
        logic [1:0] sjw;
        rest = 4'(segs - SEGS_FIRST);
        seg1 = rest >> 1;
        seg2 = rest - seg1;
        sjw  = (seg1 > 4'd3) ? 2'd3 : seg1[1:0];
        return {seg2[2:0], seg1, sjw, 1'b0, qm1};
    endfunction

    logic [CLK_W-1:0]  r_clk_hz;
    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_rem;
    logic [CLK_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_div;
    logic [QM1_W-1:0]  r_qm1;
    logic [SEGS_W-1:0] r_segs;
    logic [STEP_W-1:0] r_step;
    logic              r_found;
    logic [DIV_W-1:0]  r_prescale_div;
    logic [WORD_W-1:0] r_timing_word;

    logic [RATE_W:0]   w_trial;
    logic [RATE_W:0]   w_diff;
    logic              w_ge;
    logic [PROD_W-1:0] w_prod;

    // Restoring divide: bring down one dividend bit a cycle.
    assign w_trial = {r_rem, r_quo[CLK_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_rate});
    assign w_diff  = w_trial - {1'b0, r_rate};

    assign w_prod  = PROD_W'(r_segs) * PROD_W'(r_step);

    assign o_status.rate_zero   = (i_bit_rate == '0);
    assign o_status.div_last    = (r_cnt == DIV_STEPS_LAST);
    assign o_status.match       = (CLK_W'(w_prod) == r_quo);
    assign o_status.search_last = (r_div == DIV_LAST) && (r_qm1 == QM1_LAST) &&
                                  (r_segs == SEGS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_RESET;
        end else if (i_cfg_we) begin
            r_clk_hz <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rate <= i_bit_rate;
            r_quo  <= r_clk_hz;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            r_quo  <= {r_quo[CLK_W-2:0], w_ge};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    // Walk div (outer), quanta (middle), segs (inner); keep step = quanta*(div+1).
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_div  <= '0;
            r_qm1  <= '0;
            r_segs <= SEGS_FIRST;
            r_step <= STEP_W'(1);
        end else if (i_cmd.search_step) begin
            if (r_segs == SEGS_LAST) begin
                r_segs <= SEGS_FIRST;
                if (r_qm1 == QM1_LAST) begin
                    r_qm1  <= '0;
                    r_div  <= r_div + DIV_W'(1);
                    r_step <= STEP_W'(r_div) + STEP_W'(2);
                end else begin
                    r_qm1  <= r_qm1 + QM1_W'(1);
                    r_step <= r_step + STEP_W'(r_div) + STEP_W'(1);
                end
            end else begin
                r_segs <= r_segs + SEGS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_found        <= 1'b1;
            r_prescale_div <= r_div;
            r_timing_word  <= pack_word(r_qm1, r_segs);
        end else if (i_cmd.clear) begin
            r_found        <= 1'b0;
            r_prescale_div <= '0;
            r_timing_word  <= '0;
        end
    end

    assign o_found        = r_found;
    assign o_prescale_div = r_prescale_div;
    assign o_timing_word  = r_timing_word;

endmodule

### hdl/cbts_ctrl.sv
// Controller of the CAN bit timing search: sequences divide and walk,
// drives busy and the result strobe. Depends on cbts_pkg.
module cbts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cbts_pkg::t_status i_status,
    output cbts_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);
    import cbts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_strobe, n_strobe;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd    = '0;
        n_state  = r_state;
        n_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_status.rate_zero) begin
                        w_cmd.clear = 1'b1;
                        n_strobe    = 1'b1;
                    end else begin
                        w_cmd.load = 1'b1;
                        n_state    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    w_cmd.search_init = 1'b1;
                    n_state           = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.match) begin
                    w_cmd.capture = 1'b1;
                    n_strobe      = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_status.search_last) begin
                    w_cmd.clear = 1'b1;
                    n_strobe    = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    w_cmd.search_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign o_cmd    = w_cmd;
    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

### hdl/can_bit_timing_search.sv
// Top level of the CAN bit timing search block.
// Instantiates cbts_ctrl and cbts_datapath; depends on cbts_pkg.
//
// Usage:
//   Request channel: drive i_bit_rate and raise start; the request is taken
//   at a rising edge with start high and busy low. busy stays high while
//   the request is worked on.
//   Result channel: o_strobe is high for exactly one cycle; o_found,
//   o_prescale_div and o_timing_word are valid in that cycle and hold
//   until the next result. There is no back-pressure: capture the result
//   when o_strobe is high, the block never waits for the receiver.
//   Configuration: i_cfg_valid/o_cfg_ready/i_cfg_data write the peripheral
//   clock in hertz; o_cfg_ready is high whenever busy is low.
// Operation:
//   A zero bit rate gives a not-found result in the cycle after the request.
//   Otherwise a restoring divider first computes clocks per bit, then
//   the walk tests one (divider, quanta, segments) combination per cycle,
//   up to 7680 of them, and the strobe reports the first match or, if
//   there is none, a not-found result.
//   One request at a time; a new one may be given in the strobe cycle.
// Reset:
//   Synchronous, active low. Returns to idle, drops busy and the strobe,
//   and loads the peripheral clock with 48 MHz.
module can_bit_timing_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cbts_pkg::RATE_W-1:0]   i_bit_rate,
    output logic                          o_strobe,
    output logic                          o_found,
    output logic [cbts_pkg::DIV_W-1:0]    o_prescale_div,
    output logic [cbts_pkg::WORD_W-1:0]   o_timing_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbts_pkg::CLK_W-1:0]    i_cfg_data
);
    import cbts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;
    logic    w_cfg_we;

    // Take clock writes only while no request is in flight.
    assign o_cfg_ready = !w_busy;
    assign w_cfg_we    = i_cfg_valid && !w_busy;
    assign busy        = w_busy;

    // Sequence the request: divide, walk, then report.
    cbts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy),
        .o_strobe (o_strobe)
    );

    // Hold the clock setting, compute clocks per bit and walk combinations.
    cbts_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_bit_rate     (i_bit_rate),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_found        (o_found),
        .o_prescale_div (o_prescale_div),
        .o_timing_word  (o_timing_word)
    );

endmodule

### hdl/cbts_checker.sv
// Port-level checks for the CAN bit timing search block, and the bind
// that attaches them to can_bit_timing_search. Depends on cbts_pkg.
module cbts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic                          o_found,
    input logic [cbts_pkg::DIV_W-1:0]    o_prescale_div,
    input logic [cbts_pkg::WORD_W-1:0]   o_timing_word,
    input logic                          o_cfg_ready
);

    // A result follows either a request offered while idle or a running search.
    a_strobe_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start || busy))
        else $error("result strobe without a request");

    // A taken request either goes busy or reports at once.
    a_request_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("request taken without busy or result");

    // Busy ends only with a result.
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // A not-found result carries zero fields.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_prescale_div == '0 && o_timing_word == '0))
        else $error("not-found result with nonzero fields");

    // No clock writes while a request is in flight.
    a_cfg_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready)
        else $error("configuration ready while busy");

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (.*);
